>>> rtl/core/mbp_pkg.sv
// Shared types, constants and character tables of the multipart byteranges parser.
package mbp_pkg;

   localparam int MaxBoundaryDefault = 72;
   localparam int QueueDepth = 2;
   localparam int NameLen = 13;

   localparam logic [7:0] ChLf = 8'd10;
   localparam logic [7:0] ChCr = 8'd13;
   localparam logic [7:0] ChDash = 8'h2d;
   localparam logic [7:0] ChColon = 8'h3a;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChPlus = 8'h2b;

   localparam logic [1:0] KindData = 2'd0;
   localparam logic [1:0] KindRange = 2'd1;
   localparam logic [1:0] KindMalformed = 2'd2;
   localparam logic [1:0] KindFraming = 2'd3;

   localparam logic RegBoundaryLength = 1'b0;
   localparam logic RegResumeLastTo = 1'b1;

   typedef struct packed {
      logic       load;
      logic [7:0] byte_value;
      logic [6:0] boundary_index;
      logic       buffer_end;
      logic       is_ws;
      logic       is_digit;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [63:0] range_from;
      logic [63:0] range_to;
   } result_type;

   function automatic logic [7:0] name_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0: ch = 8'h43;
         4'd1: ch = 8'h6f;
         4'd2: ch = 8'h6e;
         4'd3: ch = 8'h74;
         4'd4: ch = 8'h65;
         4'd5: ch = 8'h6e;
         4'd6: ch = 8'h74;
         4'd7: ch = 8'h2d;
         4'd8: ch = 8'h52;
         4'd9: ch = 8'h61;
         4'd10: ch = 8'h6e;
         4'd11: ch = 8'h67;
         4'd12: ch = 8'h65;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] unit_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0: ch = 8'h62;
         4'd1: ch = 8'h79;
         4'd2: ch = 8'h74;
         4'd3: ch = 8'h65;
         4'd4: ch = 8'h73;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/core/mbp_front.sv
// Front end: accepts requests, classifies the byte and queues them for the back end.
module mbp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,
   input  logic              req_tuser,
   input  logic              req_tlast,
   output logic              head_valid,
   output mbp_pkg::item_type head_item,
   input  logic              head_pop
);
   import mbp_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   item_type             queue_ff [QueueDepth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]        count_ff, count_in;
   item_type             new_item;
   logic                 push;

   always_comb begin
      new_item.load           = req_tuser;
      new_item.byte_value     = req_tdata[7:0];
      new_item.boundary_index = req_tdata[14:8];
      new_item.buffer_end     = req_tlast;
      new_item.is_ws          = (req_tdata[7:0] == ChSpace) ||
                                (req_tdata[7:0] >= 8'd9 && req_tdata[7:0] <= 8'd13);
      new_item.is_digit       = (req_tdata[7:0] >= 8'h30) && (req_tdata[7:0] <= 8'h39);
   end

   assign req_tready = (count_ff != (PtrW+1)'(QueueDepth));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign head_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> rtl/core/mbp_back.sv
// Back end: boundary store, parse state machine and registered result stage.
module mbp_back #(
   parameter int MaxBoundary = mbp_pkg::MaxBoundaryDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  mbp_pkg::item_type   head_item,
   output logic                head_pop,
   input  logic [6:0]          boundary_length,
   input  logic [63:0]         resume_last_to,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output mbp_pkg::result_type rsp_result
);
   import mbp_pkg::*;

   localparam int AW = $clog2(MaxBoundary);
   localparam int PW = $clog2(MaxBoundary + 2);

   localparam logic [3:0] PhBound      = 4'd0;
   localparam logic [3:0] PhFieldStart = 4'd1;
   localparam logic [3:0] PhField      = 4'd2;
   localparam logic [3:0] PhHdrEnd     = 4'd3;
   localparam logic [3:0] PhValStart   = 4'd4;
   localparam logic [3:0] PhVal        = 4'd5;
   localparam logic [3:0] PhValEnd     = 4'd6;
   localparam logic [3:0] PhData       = 4'd7;
   localparam logic [3:0] PhEnd        = 4'd8;

   localparam logic [3:0] VpWsF   = 4'd5;
   localparam logic [3:0] VpSignF = 4'd6;
   localparam logic [3:0] VpDigF  = 4'd7;
   localparam logic [3:0] VpWsT   = 4'd8;
   localparam logic [3:0] VpSignT = 4'd9;
   localparam logic [3:0] VpDigT  = 4'd10;
   localparam logic [3:0] VpDone  = 4'd11;
   localparam logic [3:0] VpBad   = 4'd12;

   logic [7:0]    store_mem [MaxBoundary];
   logic [7:0]    rd_data_ff;
   logic [7:0]    byte0_ff;

   logic [3:0]    phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [3:0]    fmp_ff, fmp_in;
   logic          fmm_ff, fmm_in;
   logic [3:0]    vp_ff, vp_in;
   logic [63:0]   from_ff, from_in, to_ff, to_in, rem_ff, rem_in;
   logic          drop_ff, drop_in;

   logic          out_valid_ff;
   result_type    out_ff;
   logic          emit;
   result_type    res;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [PW-1:0] len;
   logic [7:0]    c, sb;
   logic          go, ferr;
   logic [67:0]   acc;
   logic [63:0]   acc_val;

   assign head_pop   = head_valid && (!out_valid_ff || rsp_tready);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

   assign c       = head_item.byte_value;
   assign wr_en   = head_pop && head_item.load &&
                    ({2'b00, head_item.boundary_index} < 9'(MaxBoundary));
   assign wr_addr = AW'(head_item.boundary_index);
   assign rd_addr = ({1'b0, pos_in} < (PW+1)'(MaxBoundary)) ? AW'(pos_in) : '0;

   always_comb begin
      if ({2'b00, boundary_length} > 9'(MaxBoundary)) begin
         len = PW'(MaxBoundary);
      end else begin
         len = PW'(boundary_length);
      end
   end

   // Decimal accumulate: v*10 + d, saturating when it leaves 64 bits.
   always_comb begin
      if (vp_ff == VpDigT) begin
         acc = ({4'b0, to_ff} << 3) + ({4'b0, to_ff} << 1) + 68'(c[3:0]);
      end else begin
         acc = ({4'b0, from_ff} << 3) + ({4'b0, from_ff} << 1) + 68'(c[3:0]);
      end
      acc_val = (acc[67:64] != 4'd0) ? 64'hffff_ffff_ffff_ffff : acc[63:0];
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      fmp_in   = fmp_ff;
      fmm_in   = fmm_ff;
      vp_in    = vp_ff;
      from_in  = from_ff;
      to_in    = to_ff;
      rem_in   = rem_ff;
      drop_in  = drop_ff;
      emit     = 1'b0;
      ferr     = 1'b0;
      go       = 1'b0;
      sb       = 8'd0;
      res      = '0;
      if (head_pop && !head_item.load) begin
         if (drop_ff) begin
            if (head_item.buffer_end) begin
               drop_in = 1'b0;
            end
         end else begin
            go = 1'b1;
         end
      end

      if (go && phase_in == PhData) begin
         if (rem_ff != 64'd0) begin
            rem_in = rem_ff - 64'd1;
            if (rem_ff == 64'd1) begin
               phase_in = PhBound;
               pos_in   = '0;
            end
            emit          = 1'b1;
            res.kind      = KindData;
            res.data_byte = c;
            go            = 1'b0;
         end else begin
            phase_in = PhBound;
            pos_in   = '0;
         end
      end

      if (go && phase_in == PhBound) begin
         go = 1'b0;
         if ({1'b0, pos_in} > {1'b0, len} + 1'b1) begin
            pos_in = '0;
         end
         sb = (pos_in == '0) ? byte0_ff : rd_data_ff;
         if (pos_in == len) begin
            if (c != ChCr && c != ChDash) begin
               ferr = 1'b1;
            end else begin
               pos_in = pos_in + 1'b1;
            end
         end else if ({1'b0, pos_in} == {1'b0, len} + 1'b1) begin
            if (c != ChLf && c != ChDash) begin
               ferr = 1'b1;
            end else begin
               pos_in   = '0;
               phase_in = (c == ChDash) ? PhEnd : PhFieldStart;
            end
         end else if (c != sb) begin
            if (c != ChCr && c != ChLf) begin
               ferr = 1'b1;
            end
         end else begin
            pos_in = pos_in + 1'b1;
         end
      end

      if (go && phase_in == PhFieldStart) begin
         fmp_in   = 4'd0;
         fmm_in   = 1'b0;
         phase_in = PhField;
      end

      if (go && phase_in == PhField) begin
         go = 1'b0;
         if (c == ChCr) begin
            phase_in = PhHdrEnd;
         end else if (c == ChColon) begin
            phase_in = PhValStart;
         end else if (!fmm_in && fmp_in < 4'(NameLen) && c == name_char(fmp_in)) begin
            fmp_in = fmp_in + 4'd1;
         end else begin
            fmm_in = 1'b1;
         end
      end

      if (go && phase_in == PhHdrEnd) begin
         go = 1'b0;
         if (c != ChLf) begin
            ferr = 1'b1;
         end else begin
            phase_in = PhData;
         end
      end

      if (go && phase_in == PhValStart) begin
         vp_in   = 4'd0;
         from_in = 64'd0;
         to_in   = 64'd0;
         if (c == ChSpace) begin
            go = 1'b0;
         end else begin
            phase_in = PhVal;
         end
      end

      if (go && phase_in == PhVal) begin
         go = 1'b0;
         if (c != ChCr) begin
            if (vp_in < 4'd5) begin
               vp_in = (c == unit_char(vp_in)) ? vp_in + 4'd1 : VpBad;
            end else if (vp_in == VpWsF || vp_in == VpWsT) begin
               if (head_item.is_ws) begin
                  vp_in = vp_in;
               end else if (c == ChPlus) begin
                  vp_in = (vp_in == VpWsT) ? VpSignT : VpSignF;
               end else if (head_item.is_digit) begin
                  if (vp_in == VpWsT) begin
                     to_in = 64'(c[3:0]);
                     vp_in = VpDigT;
                  end else begin
                     from_in = 64'(c[3:0]);
                     vp_in   = VpDigF;
                  end
               end else begin
                  vp_in = VpBad;
               end
            end else if (vp_in == VpSignF || vp_in == VpSignT) begin
               if (head_item.is_digit) begin
                  if (vp_in == VpSignT) begin
                     to_in = 64'(c[3:0]);
                     vp_in = VpDigT;
                  end else begin
                     from_in = 64'(c[3:0]);
                     vp_in   = VpDigF;
                  end
               end else begin
                  vp_in = VpBad;
               end
            end else if (vp_in == VpDigF) begin
               if (head_item.is_digit) begin
                  from_in = acc_val;
               end else begin
                  vp_in = (c == ChDash) ? VpWsT : VpBad;
               end
            end else if (vp_in == VpDigT) begin
               if (head_item.is_digit) begin
                  to_in = acc_val;
               end else begin
                  vp_in = VpDone;
               end
            end
         end else begin
            phase_in = PhValEnd;
            if (!fmm_in && fmp_in == 4'(NameLen)) begin
               if (vp_in != VpDigT && vp_in != VpDone) begin
                  rem_in   = 64'd0;
                  emit     = 1'b1;
                  res.kind = KindMalformed;
               end else begin
                  rem_in = to_in - from_in + 64'd1;
                  if (to_in != resume_last_to) begin
                     emit           = 1'b1;
                     res.kind       = KindRange;
                     res.range_from = from_in;
                     res.range_to   = to_in;
                  end
               end
            end
         end
      end

      if (go && phase_in == PhValEnd) begin
         go = 1'b0;
         if (c != ChLf) begin
            ferr = 1'b1;
         end else begin
            phase_in = PhFieldStart;
         end
      end

      if (ferr) begin
         emit     = 1'b1;
         res      = '0;
         res.kind = KindFraming;
         if (!head_item.buffer_end) begin
            drop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhBound;
         pos_ff       <= '0;
         fmp_ff       <= 4'd0;
         fmm_ff       <= 1'b0;
         vp_ff        <= 4'd0;
         from_ff      <= 64'd0;
         to_ff        <= 64'd0;
         rem_ff       <= 64'd0;
         drop_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         fmp_ff   <= fmp_in;
         fmm_ff   <= fmm_in;
         vp_ff    <= vp_in;
         from_ff  <= from_in;
         to_ff    <= to_in;
         rem_ff   <= rem_in;
         drop_ff  <= drop_in;
         if (head_pop && emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop && emit) begin
         out_ff <= res;
      end
   end

   // Prefetch the entry at the next position; forward a load to the same entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= c;
      end
      if (wr_en && wr_addr == rd_addr) begin
         rd_data_ff <= c;
      end else begin
         rd_data_ff <= store_mem[rd_addr];
      end
      if (wr_en && wr_addr == '0) begin
         byte0_ff <= c;
      end
   end

endmodule

>>> rtl/core/multipart_byteranges_parser.sv
// Top level of the multipart/byteranges body parser: CSR port, front end and back end.
// A request's result appears on rsp once it has left the queue and the parse stage has loaded
// the output register; a load or silent byte gives none.
// Throughput: one request per cycle while rsp_tready holds, set by the parse step in the
// back end, which also does the decimal accumulate and the boundary store prefetch.
// Reset: synchronous, active high; clears phase, counters and queue, not the boundary store.
module multipart_byteranges_parser #(
   parameter int MaxBoundary = mbp_pkg::MaxBoundaryDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [7:0] byte_value, [14:8] boundary_index, [15] zero
   input  logic         req_tuser,   // [0] operation (1 = load boundary byte)
   input  logic         req_tlast,   // buffer_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // [7:0] data_byte, [71:8] range_from, [135:72] range_to
   output logic [1:0]   rsp_tuser,   // [1:0] kind
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   import mbp_pkg::*;

   logic [6:0]  boundary_length_ff;
   logic [63:0] resume_last_to_ff;
   logic        cfg_write;
   logic        head_valid, head_pop;
   item_type    head_item;
   result_type  result;

   // Register decode uses address bit 3 only: register 0 at 0, register 1 at 8.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[3] == RegResumeLastTo) ? resume_last_to_ff
                                                         : {57'd0, boundary_length_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         boundary_length_ff <= 7'd1;
         resume_last_to_ff  <= 64'd0;
      end else if (cfg_write) begin
         if (csr_paddr[3] == RegBoundaryLength) begin
            boundary_length_ff <= csr_pwdata[6:0];
         end else begin
            resume_last_to_ff <= csr_pwdata;
         end
      end
   end

   // Front: take each request and classify it into the queue.
   mbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   // Back: advance the parse state and hold each result until taken.
   mbp_back #(
      .MaxBoundary (MaxBoundary)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop),
      .boundary_length (boundary_length_ff),
      .resume_last_to  (resume_last_to_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_result      (result)
   );

   assign rsp_tuser = result.kind;
   assign rsp_tdata = {result.range_to, result.range_from, result.data_byte};

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the multipart byteranges parser.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mbp_pkg::*;

   // Boundary search, header, value, payload and end phases of the parser, as tracked by the predictor.
   typedef enum logic [3:0] {
      PhBound, PhFieldStart, PhField, PhHdrEnd, PhValStart, PhVal, PhValEnd, PhData, PhEnd
   } phase_type;

   // Steps of the Content-Range value scan after the unit word.
   localparam int unsigned VpWsFrom = 5;
   localparam int unsigned VpSignFrom = 6;
   localparam int unsigned VpDigFrom = 7;
   localparam int unsigned VpWsTo = 8;
   localparam int unsigned VpSignTo = 9;
   localparam int unsigned VpDigTo = 10;
   localparam int unsigned VpDone = 11;
   localparam int unsigned VpBad = 12;

   localparam int StoreDepth = MaxBoundaryDefault;
   localparam logic [3:0] AddrBoundaryLength = 4'd0;
   localparam logic [3:0] AddrResumeLastTo = 4'd8;
   localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int StallLimit = 20000;
   localparam int RandomItems = 120;
   localparam int PhaseItems = 30;

   localparam string HeaderName = "Content-Range";
   localparam string UnitWord = "bytes";

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [63:0]  csr_pwdata = '0;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   multipart_byteranges_parser i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: a private copy of the parser and its registers.
   logic [6:0]     boundary_len_reg = 7'd1;
   logic [63:0]    resume_reg = '0;
   phase_type      phase = PhBound;
   int unsigned    bound_pos = 0;
   logic [7:0]     bound_store [StoreDepth];
   int unsigned    name_pos = 0;
   bit             name_miss = 1'b0;
   int unsigned    value_step = 0;
   logic [63:0]    range_lo = '0;
   logic [63:0]    range_hi = '0;
   logic [63:0]    payload_left = '0;
   bit             dropping = 1'b0;

   result_type     pending_results [$];
   int             error_count = 0;
   int             requests_sent = 0;
   int             kind_seen [4] = '{0, 0, 0, 0};
   int             idle_cycles = 0;

   // Sender burst shaping and receiver stall control.
   bit             sender_gaps = 1'b1;
   int             burst_left = 0;
   int             hold_off = 0;
   int             stall_mode = 0;
   int             stall_tick = 0;

   function automatic void push_result(logic [1:0] kind, logic [7:0] data,
                                       logic [63:0] lo, logic [63:0] hi);
      result_type r;
      r.kind = kind;
      r.data_byte = data;
      r.range_from = lo;
      r.range_to = hi;
      pending_results.push_back(r);
   endfunction

   function automatic void framing_fault(bit last);
      if (!last) dropping = 1'b1;
      push_result(KindFraming, 8'd0, '0, '0);
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == ChSpace || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Decimal accumulate, saturating at all ones.
   function automatic logic [63:0] add_digit(logic [63:0] v, logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - "0");
      if (v > (AllOnes - d) / 10) return AllOnes;
      return v * 10 + d;
   endfunction

   function automatic void scan_value(logic [7:0] c);
      bit hi;
      hi = value_step == VpWsTo || value_step == VpSignTo;
      if (value_step < 5) begin
         value_step = (c == UnitWord[value_step]) ? value_step + 1 : VpBad;
      end else if (value_step == VpWsFrom || value_step == VpWsTo) begin
         if (is_space(c)) begin
         end else if (c == ChPlus) begin
            value_step = hi ? VpSignTo : VpSignFrom;
         end else if (is_num(c)) begin
            if (hi) range_hi = 64'(c - "0");
            else range_lo = 64'(c - "0");
            value_step = hi ? VpDigTo : VpDigFrom;
         end else begin
            value_step = VpBad;
         end
      end else if (value_step == VpSignFrom || value_step == VpSignTo) begin
         if (is_num(c)) begin
            if (hi) range_hi = 64'(c - "0");
            else range_lo = 64'(c - "0");
            value_step = hi ? VpDigTo : VpDigFrom;
         end else begin
            value_step = VpBad;
         end
      end else if (value_step == VpDigFrom) begin
         if (is_num(c)) range_lo = add_digit(range_lo, c);
         else value_step = (c == ChDash) ? VpWsTo : VpBad;
      end else if (value_step == VpDigTo) begin
         if (is_num(c)) range_hi = add_digit(range_hi, c);
         else value_step = VpDone;
      end
   endfunction

   function automatic void parse_body(logic [7:0] c, bit last);
      int unsigned len;
      if (phase == PhData) begin
         if (payload_left != 0) begin
            payload_left -= 1;
            if (payload_left == 0) begin
               phase = PhBound;
               bound_pos = 0;
            end
            push_result(KindData, c, '0, '0);
            return;
         end
         phase = PhBound;
         bound_pos = 0;
      end
      if (phase == PhBound) begin
         len = (boundary_len_reg > StoreDepth) ? StoreDepth : boundary_len_reg;
         if (bound_pos > len + 1) bound_pos = 0;
         if (bound_pos == len) begin
            if (c != ChCr && c != ChDash) framing_fault(last);
            else bound_pos += 1;
         end else if (bound_pos == len + 1) begin
            if (c != ChLf && c != ChDash) begin
               framing_fault(last);
            end else begin
               bound_pos = 0;
               phase = (c == ChDash) ? PhEnd : PhFieldStart;
            end
         end else if (c != bound_store[bound_pos]) begin
            if (c != ChCr && c != ChLf) framing_fault(last);
         end else begin
            bound_pos += 1;
         end
         return;
      end
      if (phase == PhFieldStart) begin
         name_pos = 0;
         name_miss = 1'b0;
         phase = PhField;
      end
      if (phase == PhField) begin
         if (c == ChCr) phase = PhHdrEnd;
         else if (c == ChColon) phase = PhValStart;
         else if (!name_miss && name_pos < NameLen && c == HeaderName[name_pos]) name_pos += 1;
         else name_miss = 1'b1;
         return;
      end
      if (phase == PhHdrEnd) begin
         if (c != ChLf) framing_fault(last);
         else phase = PhData;
         return;
      end
      if (phase == PhValStart) begin
         value_step = 0;
         range_lo = '0;
         range_hi = '0;
         if (c == ChSpace) return;
         phase = PhVal;
      end
      if (phase == PhVal) begin
         if (c != ChCr) begin
            scan_value(c);
            return;
         end
         phase = PhValEnd;
         if (name_miss || name_pos != NameLen) return;
         if (value_step != VpDigTo && value_step != VpDone) begin
            payload_left = '0;
            push_result(KindMalformed, 8'd0, '0, '0);
            return;
         end
         payload_left = range_hi - range_lo + 1;
         if (range_hi != resume_reg) push_result(KindRange, 8'd0, range_lo, range_hi);
         return;
      end
      if (phase == PhValEnd) begin
         if (c != ChLf) framing_fault(last);
         else phase = PhFieldStart;
      end
   endfunction

   function automatic void predict_request(bit load, logic [7:0] c, logic [6:0] idx, bit last);
      if (load) begin
         if (idx < StoreDepth) bound_store[idx] = c;
      end else if (dropping) begin
         if (last) dropping = 1'b0;
      end else begin
         parse_body(c, last);
      end
   endfunction

   // Receiver: hold off when asked, else stall on the current pattern.
   always @(posedge clock) begin
      stall_tick++;
      if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= $urandom_range(0, 3) != 0;
            end
            2: begin
               rsp_tready <= (stall_tick % 7) < 3;
            end
            default: begin
               rsp_tready <= $urandom_range(0, 1);
            end
         endcase
      end
   end

   // Check each response before the edge that accepts it; watch for a stuck run.
   always @(negedge clock) begin
      result_type want;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else if (!reset) idle_cycles++;
      if (idle_cycles >= StallLimit) begin
         $display("%0t: no handshake for %0d cycles", $time, StallLimit);
         $display("testbench: errors");
         $finish;
      end else if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response kind %0d data %h", $time, rsp_tuser,
                     rsp_tdata[7:0]);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            kind_seen[want.kind]++;
            if (rsp_tuser !== want.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[7:0] !== want.data_byte) begin
               $display("%0t: data_byte expected %h actual %h", $time, want.data_byte,
                        rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[71:8] !== want.range_from) begin
               $display("%0t: range_from expected %0d actual %0d", $time, want.range_from,
                        rsp_tdata[71:8]);
               error_count++;
            end
            if (rsp_tdata[135:72] !== want.range_to) begin
               $display("%0t: range_to expected %0d actual %0d", $time, want.range_to,
                        rsp_tdata[135:72]);
               error_count++;
            end
         end
      end
   end

   // Offer one request, after a burst gap if due, and hold it until accepted.
   task automatic send_request(bit load, logic [7:0] c, logic [6:0] idx, bit last);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= load;
      req_tdata <= {1'b0, idx, c};
      req_tlast <= last;
      do @(negedge clock); while (!req_tready);
      predict_request(load, c, idx, last);
      requests_sent++;
      @(posedge clock);
   endtask

   task automatic send_byte(logic [7:0] c);
      send_request(1'b0, c, 7'($urandom_range(0, 127)), $urandom_range(0, 19) == 0);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Wait until every predicted response has arrived, then let the pipeline settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] addr, logic [63:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == AddrBoundaryLength) boundary_len_reg = value[6:0];
      else resume_reg = value;
   endtask

   task automatic send_boundary(int count);
      for (int i = 0; i < count; i++) send_byte(bound_store[i]);
   endtask

   function automatic int boundary_span();
      return (boundary_len_reg > StoreDepth) ? StoreDepth : boundary_len_reg;
   endfunction

   // End any drop in progress with a buffer end, and finish a short payload.
   task automatic resync();
      while (dropping)
         send_request(1'b0, 8'($urandom_range(0, 255)), 7'd0, 1'b1);
      while (phase == PhData && payload_left != 0 && payload_left < 64)
         send_byte(8'($urandom_range(0, 255)));
   endtask

   // One well-formed part around the given value text, with a payload of n bytes.
   task automatic send_part(string value, int n);
      repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? ChCr : ChLf);
      send_boundary(boundary_span());
      send_text("\r\n");
      if ($urandom_range(0, 2) == 0) send_text("Content-Type: text/plain\r\n");
      send_text({"Content-Range:", value, "\r\n"});
      if ($urandom_range(0, 3) == 0) send_text("Content-Rangex: bytes 1-2\r\n");
      send_text("\r\n");
      repeat (n) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Pick a range of n bytes; some end at the resume offset so that no record is made.
   task automatic random_range(int n, output logic [63:0] lo, output logic [63:0] hi);
      case ($urandom_range(0, 5))
         0: lo = {$urandom, $urandom};
         1: lo = AllOnes - 64'($urandom_range(0, 8));
         default: lo = 64'($urandom_range(0, 5000));
      endcase
      if (lo > AllOnes - 64'(n) + 1) lo = AllOnes - 64'(n) + 1;
      hi = lo + 64'(n) - 1;
      if ($urandom_range(0, 5) == 0 && resume_reg >= 64'(n)) begin
         hi = resume_reg;
         lo = resume_reg - 64'(n) + 1;
      end
   endtask

   task automatic random_part();
      int n;
      logic [63:0] lo, hi;
      string text;
      n = $urandom_range(0, 6);
      random_range(n, lo, hi);
      case ($urandom_range(0, 4))
         0: text = $sformatf(" bytes %0d-%0d/*", lo, hi);
         1: text = $sformatf("  bytes\t+%0d- +%0d/%0d", lo, hi, hi + 1);
         2: text = $sformatf("bytes %0d-%0d", lo, hi);
         default: text = $sformatf(" bytes %0d-%0d/%0d", lo, hi, $urandom);
      endcase
      if ($urandom_range(0, 9) == 0) begin
         text = " bytes -1-5/9";
         n = 0;
      end
      send_part(text, n);
   endtask

   // Broken sequences: stray text, a wrong boundary byte, or a header CR without LF.
   task automatic broken_part();
      case ($urandom_range(0, 2))
         0: begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
         end
         1: begin
            send_boundary($urandom_range(0, boundary_span()));
            send_byte("#");
            send_text("\r\nContent-Range: bytes 1-2/3\r\n\r\nab");
         end
         default: begin
            send_boundary(boundary_span());
            send_text("\r\nContent-Type: x\rQ\r\n");
         end
      endcase
   endtask

   task automatic load_boundary();
      for (int i = 0; i < StoreDepth; i++) begin
         logic [7:0] c;
         do c = 8'($urandom_range(33, 255)); while (c == ChDash || c == ChColon);
         send_request(1'b1, c, 7'(i), $urandom_range(0, 1));
      end
   endtask

   task automatic test_boundary_loads();
      load_boundary();
      // Loads beyond the store are ignored and never give a response.
      send_request(1'b1, 8'hFF, 7'd72, 1'b1);
      send_request(1'b1, 8'h00, 7'd127, 1'b0);
      send_request(1'b1, 8'hA5, 7'($urandom_range(72, 126)), 1'b1);
   endtask

   task automatic test_directed_parts();
      csr_write(AddrBoundaryLength, 64'd1);
      csr_write(AddrResumeLastTo, 64'd0);
      send_part(" bytes 0-0/1", 1);
      send_part("bytes +5-+9/20", 5);
      send_part(" bytes 10-9/20", 0);
      send_part(" bytes 0-0/1", 1);
      send_part(" bytes 99999999999999999999999-99999999999999999999999", 1);
      send_part(" bytes 18446744073709551615-18446744073709551615/*", 1);
      send_part(" bytes -3-5/9", 0);
      send_part(" byte 3-5/9", 0);
      send_part(" bytes 3x5", 0);
      send_part(" bytes 7-", 0);
      csr_write(AddrResumeLastTo, AllOnes);
      csr_write(AddrBoundaryLength, 64'd72);
      send_part(" bytes 18446744073709551614-18446744073709551615/*", 2);
      send_part(" bytes 1-3/4", 3);
      // Framing error on the buffer's last byte: nothing is dropped after it.
      send_boundary(3);
      send_request(1'b0, "#", 7'd0, 1'b1);
      send_text("\r\n");
      resync();
      // Header CR without LF drops to the buffer end.
      send_boundary(72);
      send_text("\r\nA: b\rZ");
      resync();
      // Oversized length acts as the full store; zero expects CR or dash at once.
      csr_write(AddrBoundaryLength, 64'd100);
      send_part(" bytes 4-5/6", 2);
      csr_write(AddrBoundaryLength, 64'd0);
      send_part(" bytes 4-5/6", 2);
      // Stale position after the length shrinks.
      csr_write(AddrBoundaryLength, 64'd72);
      send_boundary(40);
      csr_write(AddrBoundaryLength, 64'd8);
      send_part(" bytes 6-8/9", 3);
      drain();
   endtask

   task automatic random_phase(int count, int length, logic [63:0] resume, int mode);
      int target;
      csr_write(AddrBoundaryLength, 64'(length));
      csr_write(AddrResumeLastTo, resume);
      stall_mode = mode;
      sender_gaps = mode != 0;
      target = requests_sent + count;
      while (requests_sent < target) begin
         resync();
         if ($urandom_range(0, 7) == 0) broken_part();
         else if ($urandom_range(0, 15) == 0) load_boundary();
         else random_part();
      end
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_traffic();
      int start;
      start = requests_sent;
      random_phase(PhaseItems, 1, 64'd0, 0);
      random_phase(PhaseItems, 72, AllOnes, 1);
      random_phase(PhaseItems, $urandom_range(2, 71), 64'($urandom_range(0, 5000)), 2);
      random_phase(PhaseItems, $urandom_range(1, 16), {$urandom, $urandom}, 3);
      while (requests_sent - start < RandomItems) begin
         resync();
         random_part();
      end
   endtask

   task automatic test_backpressure();
      csr_write(AddrBoundaryLength, 64'd4);
      csr_write(AddrResumeLastTo, 64'd0);
      resync();
      sender_gaps = 1'b0;
      hold_off = 400;
      send_part(" bytes 100-139/200", 40);
      sender_gaps = 1'b1;
      drain();
   endtask

   task automatic test_closing_dash();
      resync();
      send_boundary(boundary_span());
      send_text("--");
      // Everything after the closing dash is ignored.
      send_text("\r\nContent-Range: bytes 1-2/3\r\n\r\nxy#");
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_boundary_loads();
      test_directed_parts();
      test_backpressure();
      test_random_traffic();
      test_closing_dash();
      drain();
      repeat (10) @(posedge clock);
      $display("covered %0d requests: %0d payload bytes, %0d range records,", requests_sent,
               kind_seen[KindData], kind_seen[KindRange]);
      $display("%0d malformed ranges, %0d framing errors, back-pressure and closing dash",
               kind_seen[KindMalformed], kind_seen[KindFraming]);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/mbp_pkg.sv
rtl/core/mbp_front.sv
rtl/core/mbp_back.sv
rtl/core/multipart_byteranges_parser.sv
tb/sv/testbench.sv
